// File: hdl/iom_pkg.sv
// Package for the IOC order matcher: payload structs, codes, sizes.
// No dependencies.
package iom_pkg;

  localparam int LEVELS    = 32;
  localparam int IDX_W     = $clog2(LEVELS);
  localparam int CNT_W     = $clog2(LEVELS + 1);
  localparam int PRICE_W   = 20;
  localparam int QTY_W     = 24;
  localparam int REF_W     = 64;
  localparam int ENTRY_W   = PRICE_W + QTY_W;
  localparam int MAX_FILLS = 32;
  localparam int FILL_W    = $clog2(MAX_FILLS + 1);

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_SET   = 2'd1,
    CMD_IOC   = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_FILL    = 3'd0,
    ST_NOFILL  = 3'd1,
    ST_STORED  = 3'd2,
    ST_FULL    = 3'd3,
    ST_CLEARED = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH_RD,
    S_SRCH_CHK,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_WRITE,
    S_MATCH_RD,
    S_MATCH_CHK,
    S_RESULT
  } fsm_t;

  typedef struct packed {
    logic [1:0]         cmd;
    logic               side;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   quantity;
    logic [REF_W-1:0]   order_ref;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [REF_W-1:0]   trade_ref;
    logic [REF_W-1:0]   order_echo;
    logic               order_side;
    logic [PRICE_W-1:0] fill_price;
    logic [QTY_W-1:0]   fill_quantity;
    logic [QTY_W-1:0]   remaining_quantity;
    logic               last;
  } out_item_t;

  // One book port: a synchronous RAM access request.
  typedef struct packed {
    logic               we;
    logic               tbl;   // 0 bid, 1 ask
    logic [IDX_W-1:0]   waddr;
    logic [ENTRY_W-1:0] wdata;
    logic [IDX_W-1:0]   raddr;
  } mem_req_t;

endpackage

// File: hdl/ioc_order_matcher.sv
// Top level of the IOC order matcher: sequencer over the two book RAMs.
// Depends on iom_pkg, iom_book.
//
// One item at a time; the block takes a new item whenever the sequencer is
// idle, even while the last result still waits in the output register. Clear
// goes straight to the result. Set level reads the side entry by entry to find
// the price or the insert point, shifts the tail one entry a pass on insert or
// remove, and then writes the entry (not on a remove) and issues the result. An
// IOC order examines the levels one by one, shifts the tail down each time an
// emptied level is removed, and then finishes. All cost comes from the single
// read port with registered read data on the book RAMs. A fill waits in a
// pending register until the next level or the end of the order decides its
// last flag; any result stalls only while the output register is held by
// out_ready.
module ioc_order_matcher (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  iom_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output iom_pkg::out_item_t  out_data
);
  import iom_pkg::*;

  fsm_t               state_r, state_nxt;
  in_item_t           item_r;
  out_item_t          res_r, res_nxt;
  logic               res_v_r, res_v_nxt;
  out_item_t          pend_r, pend_nxt;
  logic               pend_v_r, pend_v_nxt;
  status_t            stat_r, stat_nxt;
  logic [CNT_W-1:0]   bid_cnt_r, bid_cnt_nxt;
  logic [CNT_W-1:0]   ask_cnt_r, ask_cnt_nxt;
  logic [REF_W-1:0]   trade_r, trade_nxt;
  logic [CNT_W-1:0]   idx_r, idx_nxt;     // search / match position
  logic [CNT_W-1:0]   sidx_r, sidx_nxt;   // shift cursor
  logic [CNT_W-1:0]   send_r, send_nxt;   // shift stop index
  logic               sdir_r, sdir_nxt;   // 1 insert (move up), 0 remove (move down)
  logic               cont_r, cont_nxt;   // after shift: resume match
  logic [QTY_W-1:0]   rem_r, rem_nxt;
  logic [FILL_W-1:0]  fills_r, fills_nxt;

  mem_req_t           req;
  logic [ENTRY_W-1:0] rdata;
  logic [PRICE_W-1:0] lp;
  logic [QTY_W-1:0]   lv, tq;
  logic [CNT_W-1:0]   cnt_sel;
  logic               tbl, take, out_free;
  logic               scan_end, side_full, hit, ins_pt, qty_zero, crosses;
  logic               match_end, emptied, more_after, pend_block, shift_done, no_fills;
  out_item_t          fill_d, done_d;

  iom_book u_book (.clk(clk), .req(req), .rdata(rdata));

  assign lp = rdata[ENTRY_W-1:QTY_W];
  assign lv = rdata[QTY_W-1:0];
  assign tq = (rem_r < lv) ? rem_r : lv;
  // set: side picks table; order: opposite table
  assign tbl = (item_r.cmd == CMD_IOC) ? !item_r.side : item_r.side;
  assign cnt_sel = tbl ? ask_cnt_r : bid_cnt_r;
  assign out_free = !res_v_r || out_ready;
  assign in_ready = (state_r == S_IDLE);
  assign take = in_valid && in_ready;
  assign out_valid = res_v_r;
  assign out_data = res_r;

  assign scan_end   = (idx_r >= cnt_sel);
  assign side_full  = (cnt_sel >= CNT_W'(LEVELS));
  assign hit        = (lp == item_r.price);
  assign ins_pt     = tbl ? (item_r.price < lp) : (item_r.price > lp);
  assign qty_zero   = (item_r.quantity == '0);
  assign crosses    = item_r.side ? (lp >= item_r.price) : (lp <= item_r.price);
  assign match_end  = scan_end || (rem_r == '0) || (fills_r >= FILL_W'(MAX_FILLS));
  assign emptied    = (lv == tq);
  assign more_after = ((idx_r + CNT_W'(1)) < cnt_sel);
  assign pend_block = pend_v_r && !out_free;
  assign no_fills   = (fills_r == '0);
  assign shift_done = sdir_r ? (sidx_r <= send_r) : ((sidx_r + CNT_W'(2)) >= send_r);

  always_comb begin
    fill_d = '0;
    fill_d.status             = ST_FILL;
    fill_d.trade_ref          = trade_r;
    fill_d.order_echo         = item_r.order_ref;
    fill_d.order_side         = item_r.side;
    fill_d.fill_price         = lp;
    fill_d.fill_quantity      = tq;
    fill_d.remaining_quantity = rem_r - tq;
    fill_d.last               = 1'b0;
  end

  always_comb begin
    done_d = '0;
    done_d.status             = stat_r;
    done_d.order_echo         = item_r.order_ref;
    done_d.order_side         = item_r.side;
    done_d.remaining_quantity = (stat_r == ST_NOFILL) ? item_r.quantity : '0;
    done_d.last               = 1'b1;
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (take) begin
          case (in_data.cmd)
            CMD_CLEAR: state_nxt = S_RESULT;
            CMD_SET:   state_nxt = S_SRCH_RD;
            CMD_IOC:   state_nxt = S_MATCH_RD;
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_SRCH_RD: begin
        if (scan_end) state_nxt = (qty_zero || side_full) ? S_RESULT : S_WRITE;
        else state_nxt = S_SRCH_CHK;
      end
      S_SRCH_CHK: begin
        if (hit) begin
          if (qty_zero) state_nxt = more_after ? S_SHIFT_RD : S_RESULT;
          else state_nxt = S_WRITE;
        end else if (ins_pt) begin
          state_nxt = (qty_zero || side_full) ? S_RESULT : S_SHIFT_RD;
        end else begin
          state_nxt = S_SRCH_RD;
        end
      end
      S_SHIFT_RD: state_nxt = S_SHIFT_WR;
      S_SHIFT_WR: begin
        if (!shift_done) state_nxt = S_SHIFT_RD;
        else if (cont_r) state_nxt = S_MATCH_RD;
        else if (sdir_r) state_nxt = S_WRITE;
        else state_nxt = S_RESULT;
      end
      S_WRITE: state_nxt = S_RESULT;
      S_MATCH_RD: begin
        if (!match_end) state_nxt = S_MATCH_CHK;
        else if (no_fills) state_nxt = S_RESULT;
        else if (out_free) state_nxt = S_IDLE;
        else state_nxt = S_MATCH_RD;
      end
      S_MATCH_CHK: begin
        if (!crosses) begin
          if (no_fills) state_nxt = S_RESULT;
          else if (out_free) state_nxt = S_IDLE;
          else state_nxt = S_MATCH_CHK;
        end else if (pend_block) begin
          state_nxt = S_MATCH_CHK;
        end else begin
          state_nxt = (emptied && more_after) ? S_SHIFT_RD : S_MATCH_RD;
        end
      end
      S_RESULT: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath, book port and result staging.
  always_comb begin
    res_nxt     = res_r;
    res_v_nxt   = res_v_r && !out_ready;
    pend_nxt    = pend_r;
    pend_v_nxt  = pend_v_r;
    stat_nxt    = stat_r;
    bid_cnt_nxt = bid_cnt_r;
    ask_cnt_nxt = ask_cnt_r;
    trade_nxt   = trade_r;
    idx_nxt     = idx_r;
    sidx_nxt    = sidx_r;
    send_nxt    = send_r;
    sdir_nxt    = sdir_r;
    cont_nxt    = cont_r;
    rem_nxt     = rem_r;
    fills_nxt   = fills_r;
    req.we      = 1'b0;
    req.tbl     = tbl;
    req.waddr   = idx_r[IDX_W-1:0];
    req.wdata   = {item_r.price, item_r.quantity};
    req.raddr   = idx_r[IDX_W-1:0];
    case (state_r)
      S_IDLE: begin
        idx_nxt   = '0;
        rem_nxt   = in_data.quantity;
        fills_nxt = '0;
        sdir_nxt  = 1'b0;
        cont_nxt  = 1'b0;
        if (take && in_data.cmd == CMD_CLEAR) begin
          bid_cnt_nxt = '0;
          ask_cnt_nxt = '0;
          stat_nxt    = ST_CLEARED;
        end
      end
      S_SRCH_RD: begin
        if (scan_end) begin
          // not found: append at end, or reject when full; a zero quantity writes nothing
          stat_nxt = (!qty_zero && side_full) ? ST_FULL : ST_STORED;
          sdir_nxt = 1'b1;
        end
      end
      S_SRCH_CHK: begin
        stat_nxt = ST_STORED;
        if (hit) begin
          sdir_nxt = 1'b0;
          if (qty_zero) begin
            if (tbl) ask_cnt_nxt = ask_cnt_r - CNT_W'(1);
            else bid_cnt_nxt = bid_cnt_r - CNT_W'(1);
            sidx_nxt = idx_r;
            send_nxt = cnt_sel;
            cont_nxt = 1'b0;
          end
        end else if (ins_pt) begin
          // sorted, so the price cannot sit further on
          if (!qty_zero && side_full) begin
            stat_nxt = ST_FULL;
          end else if (!qty_zero) begin
            sdir_nxt = 1'b1;
            sidx_nxt = cnt_sel;
            send_nxt = idx_r + CNT_W'(1);
            cont_nxt = 1'b0;
          end
        end else begin
          idx_nxt = idx_r + CNT_W'(1);
        end
      end
      S_SHIFT_RD: begin
        req.raddr = sdir_r ? IDX_W'(sidx_r - CNT_W'(1)) : IDX_W'(sidx_r + CNT_W'(1));
      end
      S_SHIFT_WR: begin
        req.we    = 1'b1;
        req.waddr = sidx_r[IDX_W-1:0];
        req.wdata = rdata;
        sidx_nxt  = sdir_r ? sidx_r - CNT_W'(1) : sidx_r + CNT_W'(1);
      end
      S_WRITE: begin
        req.we   = 1'b1;
        stat_nxt = ST_STORED;
        if (sdir_r) begin
          if (tbl) ask_cnt_nxt = ask_cnt_r + CNT_W'(1);
          else bid_cnt_nxt = bid_cnt_r + CNT_W'(1);
        end
      end
      S_MATCH_RD: begin
        if (match_end) begin
          if (no_fills) begin
            stat_nxt = ST_NOFILL;
          end else if (out_free) begin
            res_nxt      = pend_r;
            res_nxt.last = 1'b1;
            res_v_nxt    = 1'b1;
            pend_v_nxt   = 1'b0;
          end
        end
      end
      S_MATCH_CHK: begin
        if (!crosses) begin
          if (no_fills) begin
            stat_nxt = ST_NOFILL;
          end else if (out_free) begin
            res_nxt      = pend_r;
            res_nxt.last = 1'b1;
            res_v_nxt    = 1'b1;
            pend_v_nxt   = 1'b0;
          end
        end else if (!pend_block) begin
          req.we    = 1'b1;
          req.wdata = {lp, lv - tq};
          // another fill follows, so the pending one was not the last
          if (pend_v_r) begin
            res_nxt   = pend_r;
            res_v_nxt = 1'b1;
          end
          pend_nxt   = fill_d;
          pend_v_nxt = 1'b1;
          trade_nxt  = trade_r + REF_W'(1);
          fills_nxt  = fills_r + FILL_W'(1);
          rem_nxt    = rem_r - tq;
          if (emptied) begin
            if (tbl) ask_cnt_nxt = ask_cnt_r - CNT_W'(1);
            else bid_cnt_nxt = bid_cnt_r - CNT_W'(1);
            sdir_nxt = 1'b0;
            sidx_nxt = idx_r;
            send_nxt = cnt_sel;
            cont_nxt = 1'b1;
          end else begin
            idx_nxt = idx_r + CNT_W'(1);
          end
        end
      end
      S_RESULT: begin
        if (out_free) begin
          res_nxt   = done_d;
          res_v_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      res_v_r   <= 1'b0;
      pend_v_r  <= 1'b0;
      bid_cnt_r <= '0;
      ask_cnt_r <= '0;
      trade_r   <= '0;
    end else begin
      state_r   <= state_nxt;
      res_v_r   <= res_v_nxt;
      pend_v_r  <= pend_v_nxt;
      bid_cnt_r <= bid_cnt_nxt;
      ask_cnt_r <= ask_cnt_nxt;
      trade_r   <= trade_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) item_r <= in_data;
    res_r   <= res_nxt;
    pend_r  <= pend_nxt;
    stat_r  <= stat_nxt;
    idx_r   <= idx_nxt;
    sidx_r  <= sidx_nxt;
    send_r  <= send_nxt;
    sdir_r  <= sdir_nxt;
    cont_r  <= cont_nxt;
    rem_r   <= rem_nxt;
    fills_r <= fills_nxt;
  end

  // A fill always moves some quantity.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_FILL |->
      out_data.fill_quantity != '0) else $error("zero fill");

  // A stalled result holds still until taken.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed during stall");

  // No fill is left behind when a new item is taken.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !pend_v_r) else $error("pending fill at idle");

  // Side counts stay within the book depth.
  assert property (@(posedge clk) disable iff (!rst_n)
    bid_cnt_r <= CNT_W'(LEVELS) && ask_cnt_r <= CNT_W'(LEVELS))
    else $error("count overflow");
endmodule

// File: hdl/iom_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module iom_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: hdl/iom_book.sv
// Both sides of the book: one RAM per side holding {price, volume}.
// Depends on iom_pkg and iom_ram.
module iom_book (
  input  logic                      clk,
  input  iom_pkg::mem_req_t         req,
  output logic [iom_pkg::ENTRY_W-1:0] rdata
);
  import iom_pkg::*;

  logic [ENTRY_W-1:0] bid_rd;
  logic [ENTRY_W-1:0] ask_rd;
  logic               tbl_r;

  iom_ram #(.WIDTH(ENTRY_W), .DEPTH(LEVELS)) u_bid (
    .clk(clk), .we(req.we && !req.tbl), .waddr(req.waddr), .wdata(req.wdata),
    .raddr(req.raddr), .rdata(bid_rd)
  );

  iom_ram #(.WIDTH(ENTRY_W), .DEPTH(LEVELS)) u_ask (
    .clk(clk), .we(req.we && req.tbl), .waddr(req.waddr), .wdata(req.wdata),
    .raddr(req.raddr), .rdata(ask_rd)
  );

  always_ff @(posedge clk) begin
    tbl_r <= req.tbl;
  end

  assign rdata = tbl_r ? ask_rd : bid_rd;
endmodule

// File: dv/iom_checker.sv
// Result checker for the IOC order matcher: watches both channels, keeps a
// shadow book, predicts each result and compares. Depends on iom_pkg.
`timescale 1ns / 100ps
module iom_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  iom_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  iom_pkg::out_item_t out_data,
  output int                 fail_count,
  output int                 pending
);
  import iom_pkg::*;

  logic [PRICE_W-1:0] bid_px[LEVELS];
  logic [QTY_W-1:0]   bid_vol[LEVELS];
  logic [PRICE_W-1:0] ask_px[LEVELS];
  logic [QTY_W-1:0]   ask_vol[LEVELS];
  int                 bid_n, ask_n;
  logic [REF_W-1:0]   trade_seq;
  out_item_t          expected_q[$];

  task automatic report(input string what, input logic [REF_W-1:0] got,
                        input logic [REF_W-1:0] want);
    $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
    fail_count++;
  endtask

  function automatic void queue_result(out_item_t r);
    expected_q.insert(expected_q.size(), r);
  endfunction

  function automatic out_item_t mk(status_t st, logic [REF_W-1:0] tref, in_item_t it,
                                   logic [PRICE_W-1:0] fp, logic [QTY_W-1:0] fq,
                                   logic [QTY_W-1:0] rem, logic lst);
    out_item_t r;
    r.status = st; r.trade_ref = tref; r.order_echo = it.order_ref;
    r.order_side = it.side; r.fill_price = fp; r.fill_quantity = fq;
    r.remaining_quantity = rem; r.last = lst;
    return r;
  endfunction

  // Book access by side: 0 bid, 1 ask.
  function automatic logic [PRICE_W-1:0] px(logic s, int i);
    return s ? ask_px[i] : bid_px[i];
  endfunction
  function automatic logic [QTY_W-1:0] vol(logic s, int i);
    return s ? ask_vol[i] : bid_vol[i];
  endfunction
  function automatic void put(logic s, int i, logic [PRICE_W-1:0] p,
                              logic [QTY_W-1:0] v);
    if (s) begin ask_px[i] = p; ask_vol[i] = v; end
    else begin bid_px[i] = p; bid_vol[i] = v; end
  endfunction
  function automatic void remove_level(logic s, int idx);
    int n;
    n = s ? ask_n : bid_n;
    for (int i = idx; i + 1 < n; i++) put(s, i, px(s, i + 1), vol(s, i + 1));
    if (s) ask_n--; else bid_n--;
  endfunction

  function automatic status_t set_level(logic s, logic [PRICE_W-1:0] p,
                                        logic [QTY_W-1:0] v);
    int n, pos;
    n = s ? ask_n : bid_n;
    for (int i = 0; i < n; i++)
      if (px(s, i) == p) begin
        if (v == 0) remove_level(s, i); else put(s, i, p, v);
        return ST_STORED;
      end
    if (v == 0) return ST_STORED;
    if (n >= LEVELS) return ST_FULL;
    pos = n;
    for (int i = 0; i < n; i++)
      if (s ? (p < px(s, i)) : (p > px(s, i))) begin pos = i; break; end
    for (int i = n; i > pos; i--) put(s, i, px(s, i - 1), vol(s, i - 1));
    put(s, pos, p, v);
    if (s) ask_n++; else bid_n++;
    return ST_STORED;
  endfunction

  task automatic predict_results(in_item_t it);
    logic               opp;
    logic [QTY_W-1:0]   rem, tq, lv;
    logic [PRICE_W-1:0] lp;
    int                 idx, k;
    case (cmd_t'(it.cmd))
      CMD_CLEAR: begin
        bid_n = 0; ask_n = 0;
        queue_result(mk(ST_CLEARED, '0, it, '0, '0, '0, 1'b1));
      end
      CMD_SET:
        queue_result(mk(set_level(it.side, it.price, it.quantity), '0, it,
                        '0, '0, '0, 1'b1));
      CMD_IOC: begin
        opp = ~it.side;
        rem = it.quantity; idx = 0; k = 0;
        while (k < MAX_FILLS && idx < (opp ? ask_n : bid_n) && rem > 0) begin
          lp = px(opp, idx); lv = vol(opp, idx);
          if (it.side ? (lp < it.price) : (lp > it.price)) break;
          tq = rem < lv ? rem : lv;
          rem -= tq;
          put(opp, idx, lp, lv - tq);
          queue_result(mk(ST_FILL, trade_seq, it, lp, tq, rem, 1'b0));
          trade_seq++; k++;
          if (lv == tq) remove_level(opp, idx); else idx++;
        end
        if (k == 0) queue_result(mk(ST_NOFILL, '0, it, '0, '0, it.quantity, 1'b1));
        else expected_q[$].last = 1'b1;
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    out_item_t w;
    if (!rst_n) begin
      bid_n = 0; ask_n = 0; trade_seq = '0; fail_count = 0;
      expected_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          report("unexpected result", out_data.order_echo, '0);
        end else begin
          w = expected_q.pop_front();
          if (out_data.status !== w.status)
            report("status", REF_W'(out_data.status), REF_W'(w.status));
          if (out_data.trade_ref !== w.trade_ref)
            report("trade_ref", out_data.trade_ref, w.trade_ref);
          if (out_data.order_echo !== w.order_echo)
            report("order_echo", out_data.order_echo, w.order_echo);
          if (out_data.order_side !== w.order_side)
            report("order_side", REF_W'(out_data.order_side), REF_W'(w.order_side));
          if (out_data.fill_price !== w.fill_price)
            report("fill_price", REF_W'(out_data.fill_price), REF_W'(w.fill_price));
          if (out_data.fill_quantity !== w.fill_quantity)
            report("fill_quantity", REF_W'(out_data.fill_quantity),
                   REF_W'(w.fill_quantity));
          if (out_data.remaining_quantity !== w.remaining_quantity)
            report("remaining_quantity", REF_W'(out_data.remaining_quantity),
                   REF_W'(w.remaining_quantity));
          if (out_data.last !== w.last)
            report("last", REF_W'(out_data.last), REF_W'(w.last));
        end
      end
      if (in_valid && in_ready) predict_results(in_data);
    end
    pending = expected_q.size();
  end
endmodule

// File: dv/tb_top.sv
// Testbench top for the IOC order matcher: clock, reset, stimulus, verdict.
// Depends on iom_pkg, ioc_order_matcher and iom_checker.
`timescale 1ns / 100ps
module tb_top;
  import iom_pkg::*;

  localparam int STALL_LIMIT = 20000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  int        fail_count, pending;
  int        idle_cycles = 0;
  int        stall_mode = 0;
  int        price_base = 500;

  always #5 clk = ~clk;

  ioc_order_matcher DUT (.*);
  iom_checker checker_i (.*);

  // Receiver stall pattern: modes switch now and then.
  always @(posedge clk) begin
    if ($urandom_range(0, 99) == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      2: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= ($urandom_range(0, 15) != 0);
    endcase
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send(cmd_t c, logic s, logic [PRICE_W-1:0] p, logic [QTY_W-1:0] q,
                      logic [REF_W-1:0] r);
    in_item_t it;
    it.cmd = c; it.side = s; it.price = p; it.quantity = q; it.order_ref = r;
    in_valid <= 1'b1;
    in_data  <= it;
    // ready is settled mid-cycle; the next rising edge is the transfer
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    // random gap between bursts
    if ($urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  function automatic logic [REF_W-1:0] rnd_ref();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [QTY_W-1:0] rnd_qty();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return QTY_W'($urandom);
      default: return QTY_W'($urandom_range(1, 300));
    endcase
  endfunction

  initial begin
    int r;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: extremes, every command, special cases
    send(CMD_IOC, 1'b0, '1, 24'd10, '0);                  // no crossing level
    send(CMD_SET, 1'b1, '0, '1, '1);
    send(CMD_SET, 1'b1, '1, 24'd5, 64'h1);
    send(CMD_SET, 1'b0, 20'd100, 24'd7, 64'h2);
    send(CMD_SET, 1'b0, 20'd100, 24'd9, 64'h3);           // overwrite
    send(CMD_SET, 1'b0, 20'd55, 24'd0, 64'h4);            // remove absent
    send(CMD_NOP, 1'b1, '1, '1, '1);                      // ignored
    send(CMD_IOC, 1'b0, '1, 24'd0, 64'h5);                // zero quantity
    send(CMD_IOC, 1'b0, '1, '1, '1);                      // sweep asks
    send(CMD_IOC, 1'b1, '0, 24'd4, 64'h6);                // partial bid
    send(CMD_SET, 1'b0, 20'd100, 24'd0, 64'h7);           // remove
    for (int i = 0; i < LEVELS; i++)
      send(CMD_SET, 1'b1, 20'(1000 + 3 * i), 24'(i + 1), 64'(i));
    send(CMD_SET, 1'b1, 20'd1, 24'd1, 64'h8);             // full side
    send(CMD_IOC, 1'b0, '1, '1, 64'h9);                   // walk all levels
    send(CMD_CLEAR, 1'b1, '1, '1, '1);
    // random: mostly populate near a moving base and cross it
    for (int n = 0; n < 200; n++) begin
      if ($urandom_range(0, 40) == 0) price_base = $urandom_range(50, 1048000);
      r = $urandom_range(0, 99);
      if (r < 3)
        send(CMD_CLEAR, 1'($urandom_range(0, 1)), PRICE_W'($urandom),
             QTY_W'($urandom), rnd_ref());
      else if (r < 5)
        send(CMD_NOP, 1'($urandom_range(0, 1)), PRICE_W'($urandom),
             QTY_W'($urandom), rnd_ref());
      else if (r < 60)
        send(CMD_SET, 1'($urandom_range(0, 1)),
             20'(price_base + $urandom_range(0, 40) - 20),
             ($urandom_range(0, 5) == 0) ? '0 : rnd_qty(), rnd_ref());
      else if (r < 95)
        send(CMD_IOC, 1'($urandom_range(0, 1)),
             20'(price_base + $urandom_range(0, 40) - 20), rnd_qty(), rnd_ref());
      else
        send(CMD_IOC, 1'($urandom_range(0, 1)), PRICE_W'($urandom),
             QTY_W'($urandom), rnd_ref());
    end
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule
